// File: design/dad_pkg.sv
// Package: shared constants, types and register indexes of the anchor decode block.
`timescale 1ns / 1ps

package dad_pkg;

    localparam int MAX_CLASSES    = 8;
    localparam int FRAC_BITS      = 21;
    localparam int MAX_IMAGE_DIM  = 8192;

    localparam int COORD_W  = 16;
    localparam int SCORE_W  = 16;
    localparam int CLASS_W  = 3;
    localparam int CORNER_W = 13;
    localparam int EXTENT_W = 14;
    localparam int DIM_W    = 14;
    localparam int PAD_W    = 12;
    localparam int SCALE_W  = 24;
    localparam int COUNT_W  = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // 2*center - size - 32*pad, signed
    localparam int RAW_W  = 19;
    localparam int SIZE2_W = COORD_W + 1;
    localparam int POS_W  = RAW_W + SCALE_W + 1;
    localparam int LEN_W  = SIZE2_W + SCALE_W;
    // clamped corner, below 8192 pixels
    localparam int POSC_W = CORNER_W + FRAC_BITS;
    // dim * one, up to 8192 pixels
    localparam int LIM_W  = EXTENT_W + FRAC_BITS;

    typedef logic [SCORE_W-1:0] t_score;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_SCALE       = 3'd0,
        REG_PAD_LEFT        = 3'd1,
        REG_PAD_TOP         = 3'd2,
        REG_IMAGE_WIDTH     = 3'd3,
        REG_IMAGE_HEIGHT    = 3'd4,
        REG_SCORE_THRESHOLD = 3'd5,
        REG_CLASS_COUNT     = 3'd6
    } t_cfg_idx;

    // Load enables of the per-axis pipeline stages
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_en;

endpackage

// File: design/dad_anchor_if.sv
// Interface: anchor input channel (valid/ready plus anchor fields).
`timescale 1ns / 1ps

interface dad_anchor_if;
    import dad_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_width_in;
    logic [COORD_W-1:0] box_height_in;
    t_score             score_0;
    t_score             score_1;
    t_score             score_2;
    t_score             score_3;
    t_score             score_4;
    t_score             score_5;
    t_score             score_6;
    t_score             score_7;

    modport source (
        output valid, center_x, center_y, box_width_in, box_height_in,
               score_0, score_1, score_2, score_3, score_4, score_5, score_6, score_7,
        input  ready
    );

    modport sink (
        input  valid, center_x, center_y, box_width_in, box_height_in,
               score_0, score_1, score_2, score_3, score_4, score_5, score_6, score_7,
        output ready
    );
endinterface

// File: design/dad_box_if.sv
// Interface: decoded box output channel (valid/ready plus box fields).
`timescale 1ns / 1ps

interface dad_box_if;
    import dad_pkg::*;

    logic                valid;
    logic                ready;
    logic [CORNER_W-1:0] left;
    logic [CORNER_W-1:0] top;
    logic [EXTENT_W-1:0] width_out;
    logic [EXTENT_W-1:0] height_out;
    t_score              best_score;
    logic [CLASS_W-1:0]  best_class;

    modport source (
        output valid, left, top, width_out, height_out, best_score, best_class,
        input  ready
    );

    modport sink (
        input  valid, left, top, width_out, height_out, best_score, best_class,
        output ready
    );
endinterface

// File: design/dad_axis.sv
// Module: one axis of the box decode: unpad, scale, clamp corner, limit extent.
`timescale 1ns / 1ps

module dad_axis
    import dad_pkg::*;
(
    input  logic                i_clk,
    input  t_pipe_en            i_en,
    input  logic [COORD_W-1:0]  i_center,
    input  logic [COORD_W-1:0]  i_size,
    input  logic [PAD_W-1:0]    i_pad,
    input  logic [DIM_W-1:0]    i_dim,
    input  logic [SCALE_W-1:0]  i_inv_scale,
    output logic [CORNER_W-1:0] o_corner,
    output logic [EXTENT_W-1:0] o_extent
);

    logic signed [RAW_W-1:0] n_raw;
    logic signed [RAW_W-1:0] r_raw;
    logic [SIZE2_W-1:0]      r_size2;
    logic signed [POS_W-1:0] r_pos;
    logic [LEN_W-1:0]        r_len;
    logic signed [POS_W-1:0] cap;
    logic [POSC_W-1:0]       n_pos_c;
    logic [POSC_W-1:0]       r_pos_c;
    logic [LEN_W-1:0]        r_len4;
    logic [LIM_W-1:0]        limit;
    logic [LEN_W-1:0]        len_sel;

    // corner in 1/32 pixel: 2*center - size - 32*pad
    assign n_raw = $signed({2'b00, i_center, 1'b0})
                 - $signed({3'b000, i_size})
                 - $signed({2'b00, i_pad, 5'b00000});

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_raw   <= n_raw;
            r_size2 <= {i_size, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_pos <= POS_W'(r_raw) * POS_W'($signed({1'b0, i_inv_scale}));
            r_len <= LEN_W'(r_size2) * LEN_W'(i_inv_scale);
        end
    end

    // (dim - 1) pixels; negative when dim is zero
    assign cap = $signed({{(POS_W-DIM_W-FRAC_BITS){1'b0}}, i_dim, {FRAC_BITS{1'b0}}})
               - $signed(POS_W'(1) << FRAC_BITS);

    always_comb begin
        if (r_pos[POS_W-1] || cap[POS_W-1]) begin
            n_pos_c = '0;
        end else if (r_pos > cap) begin
            n_pos_c = POSC_W'(cap);
        end else begin
            n_pos_c = POSC_W'(r_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            r_pos_c <= n_pos_c;
            r_len4  <= r_len;
        end
    end

    assign limit   = {i_dim, {FRAC_BITS{1'b0}}} - LIM_W'(r_pos_c);
    assign len_sel = (r_len4 > LEN_W'(limit)) ? LEN_W'(limit) : r_len4;

    assign o_corner = r_pos_c[POSC_W-1:FRAC_BITS];
    assign o_extent = len_sel[LIM_W-1:FRAC_BITS];

endmodule

// File: design/detection_anchor_decode_core.sv
// Top level: detector anchor decode, best-class search and letterbox box mapping.
//
//  channel   dir  handshake          payload
//  i_anchor  in   valid/ready        center_x/y, box_width/height_in (Q12.4), score_0..7 (Q0.16)
//  o_box     out  valid/ready        left, top, width_out, height_out, best_score, best_class
//  i_cfg_*   in   write enable only  index 0..6, data up to 24 bits
//
// One anchor is accepted per cycle unless a stall on o_box has filled every stage;
// each anchor passes every stage below before its box is handed over on o_box.
// Stages: input register, raw/score register, multiplier register, clamp register,
// output register. The 19x25 bit multiply per axis sets the middle stage.
// Anchors below the score threshold vanish as bubbles at the second stage.
// A stall on o_box backs up stage by stage; empty stages keep taking anchors.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps

module detection_anchor_decode_core
    import dad_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dad_anchor_if.sink            i_anchor,
    dad_box_if.source             o_box,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [SCALE_W-1:0] r_inv_scale;
    logic [PAD_W-1:0]   r_pad_left;
    logic [PAD_W-1:0]   r_pad_top;
    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;
    t_score             r_score_threshold;
    logic [COUNT_W-1:0] r_class_count;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_vo;
    logic en1, en_o;
    t_pipe_en en;

    // stage 1 payload
    logic [COORD_W-1:0] r_cx, r_cy, r_bw, r_bh;
    t_score             r_score [MAX_CLASSES];

    // best-class search
    logic [COUNT_W-1:0] count;
    t_score             best;
    logic [CLASS_W-1:0] best_idx;
    logic               hit;

    // score/class travel alongside the axis pipeline
    t_score             r_best2, r_best3, r_best4;
    logic [CLASS_W-1:0] r_cls2, r_cls3, r_cls4;

    logic [DIM_W-1:0]    dim_w, dim_h;
    logic [CORNER_W-1:0] left, top;
    logic [EXTENT_W-1:0] width_out, height_out;

    logic [CORNER_W-1:0] r_left, r_top;
    logic [EXTENT_W-1:0] r_width, r_height;
    t_score              r_best_o;
    logic [CLASS_W-1:0]  r_cls_o;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale       <= SCALE_W'(65536);
            r_pad_left        <= '0;
            r_pad_top         <= '0;
            r_image_width     <= DIM_W'(640);
            r_image_height    <= DIM_W'(640);
            r_score_threshold <= SCORE_W'(16384);
            r_class_count     <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_INV_SCALE:       r_inv_scale       <= i_cfg_data[SCALE_W-1:0];
                REG_PAD_LEFT:        r_pad_left        <= i_cfg_data[PAD_W-1:0];
                REG_PAD_TOP:         r_pad_top         <= i_cfg_data[PAD_W-1:0];
                REG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[DIM_W-1:0];
                REG_SCORE_THRESHOLD: r_score_threshold <= i_cfg_data[SCORE_W-1:0];
                REG_CLASS_COUNT:     r_class_count     <= i_cfg_data[COUNT_W-1:0];
                default: ;  // writes beyond the list are dropped
            endcase
        end
    end

    // limit image size and class count to their ranges
    assign dim_w = (r_image_width > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM)
                                                           : r_image_width;
    assign dim_h = (r_image_height > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM)
                                                            : r_image_height;
    assign count = (r_class_count > COUNT_W'(MAX_CLASSES)) ? COUNT_W'(MAX_CLASSES)
                                                           : r_class_count;

    // ---------------- flow control ----------------
    // a stage loads when it is empty or its content moves on
    assign en_o   = !r_vo || o_box.ready;
    assign en.en4 = !r_v4 || en_o;
    assign en.en3 = !r_v3 || en.en4;
    assign en.en2 = !r_v2 || en.en3;
    assign en1    = !r_v1 || en.en2;

    assign i_anchor.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)    r_v1 <= i_anchor.valid;
            if (en.en2) r_v2 <= r_v1 && hit;   // drop anchors below threshold
            if (en.en3) r_v3 <= r_v2;
            if (en.en4) r_v4 <= r_v3;
            if (en_o)   r_vo <= r_v4;
        end
    end

    // ---------------- stage 1: input register ----------------
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_cx       <= i_anchor.center_x;
            r_cy       <= i_anchor.center_y;
            r_bw       <= i_anchor.box_width_in;
            r_bh       <= i_anchor.box_height_in;
            r_score[0] <= i_anchor.score_0;
            r_score[1] <= i_anchor.score_1;
            r_score[2] <= i_anchor.score_2;
            r_score[3] <= i_anchor.score_3;
            r_score[4] <= i_anchor.score_4;
            r_score[5] <= i_anchor.score_5;
            r_score[6] <= i_anchor.score_6;
            r_score[7] <= i_anchor.score_7;
        end
    end

    // first strictly greater score wins; search starts from zero at class 0
    always_comb begin
        best     = '0;
        best_idx = '0;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if ((COUNT_W'(c) < count) && (r_score[CLASS_W'(c)] > best)) begin
                best     = r_score[CLASS_W'(c)];
                best_idx = CLASS_W'(c);
            end
        end
    end

    assign hit = (best >= r_score_threshold);

    // ---------------- stages 2..4: score side band ----------------
    always_ff @(posedge i_clk) begin
        if (en.en2) begin
            r_best2 <= best;
            r_cls2  <= best_idx;
        end
        if (en.en3) begin
            r_best3 <= r_best2;
            r_cls3  <= r_cls2;
        end
        if (en.en4) begin
            r_best4 <= r_best3;
            r_cls4  <= r_cls3;
        end
    end

    // ---------------- axis datapaths ----------------
    dad_axis u_axis_x (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_center    (r_cx),
        .i_size      (r_bw),
        .i_pad       (r_pad_left),
        .i_dim       (dim_w),
        .i_inv_scale (r_inv_scale),
        .o_corner    (left),
        .o_extent    (width_out)
    );

    dad_axis u_axis_y (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_center    (r_cy),
        .i_size      (r_bh),
        .i_pad       (r_pad_top),
        .i_dim       (dim_h),
        .i_inv_scale (r_inv_scale),
        .o_corner    (top),
        .o_extent    (height_out)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_left   <= left;
            r_top    <= top;
            r_width  <= width_out;
            r_height <= height_out;
            r_best_o <= r_best4;
            r_cls_o  <= r_cls4;
        end
    end

    assign o_box.valid      = r_vo;
    assign o_box.left       = r_left;
    assign o_box.top        = r_top;
    assign o_box.width_out  = r_width;
    assign o_box.height_out = r_height;
    assign o_box.best_score = r_best_o;
    assign o_box.best_class = r_cls_o;

    // ---------------- assertions ----------------
    // a box only leaves if its score passed the threshold
    a_score_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_best_o >= r_score_threshold))
        else $error("box below score threshold");

    // corner stays inside the image
    a_left_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> ((CORNER_W'(0) == r_left) || ({1'b0, r_left} < dim_w)))
        else $error("left edge outside image");

    // the box never runs past the image edge
    a_width_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (({1'b0, r_left} + {1'b0, r_width}) <= {1'b0, dim_w}))
        else $error("box width past image edge");

    // winning class lies among the classes in use
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> ((r_cls_o == CLASS_W'(0)) || ({1'b0, r_cls_o} < count)))
        else $error("best class outside class count");

    // input back-pressure only when every stage is full and the output stalls
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_anchor.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_vo && !o_box.ready))
        else $error("input stalled with room in the pipeline");

endmodule
